// File: src/jsu_pkg.sv
// Package for the JSON string unescaper: codes, constants and the UTF-8 check step.
`default_nettype none
package jsu_pkg;

    // Result kinds
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_OK   = 2'd1;
    localparam logic [1:0] KIND_BAD  = 2'd2;

    // Most results one input word can cause
    localparam int unsigned MAX_RES = 4;

    // Characters of interest
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B = 8'h62;
    localparam logic [7:0] CH_F = 8'h66;
    localparam logic [7:0] CH_N = 8'h6E;
    localparam logic [7:0] CH_R = 8'h72;
    localparam logic [7:0] CH_T = 8'h74;
    localparam logic [7:0] CH_U = 8'h75;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Allowed range of the next continuation byte
    localparam logic [2:0] RNG_ANY  = 3'd0;  // 80..BF
    localparam logic [2:0] RNG_A0BF = 3'd1;
    localparam logic [2:0] RNG_809F = 3'd2;
    localparam logic [2:0] RNG_90BF = 3'd3;
    localparam logic [2:0] RNG_808F = 3'd4;

    typedef struct packed {
        logic       ok;
        logic [1:0] pend;
        logic [2:0] rng;
    } t_utf8;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_FAIL,
        ACT_CLOSE,
        ACT_EMIT
    } t_act;

    // One step of the strict UTF-8 validator
    function automatic t_utf8 utf8_step(input logic [1:0] pend, input logic [2:0] rng,
                                        input logic [7:0] b);
        t_utf8      r;
        logic [7:0] lo;
        logic [7:0] hi;
        r    = '{ok: 1'b0, pend: pend, rng: rng};
        lo   = 8'h80;
        hi   = 8'hBF;
        if (pend != 2'd0) begin
            case (rng)
                RNG_A0BF: lo = 8'hA0;
                RNG_809F: hi = 8'h9F;
                RNG_90BF: lo = 8'h90;
                RNG_808F: hi = 8'h8F;
                default:  lo = 8'h80;
            endcase
            if (b >= lo && b <= hi) begin
                r.ok   = 1'b1;
                r.pend = pend - 2'd1;
                r.rng  = RNG_ANY;
            end
        end else if (b < 8'h80) begin
            r.ok = 1'b1;
        end else if (b >= 8'hC2 && b <= 8'hDF) begin
            r = '{ok: 1'b1, pend: 2'd1, rng: RNG_ANY};
        end else if (b == 8'hE0) begin
            r = '{ok: 1'b1, pend: 2'd2, rng: RNG_A0BF};
        end else if (b == 8'hED) begin
            r = '{ok: 1'b1, pend: 2'd2, rng: RNG_809F};
        end else if (b >= 8'hE1 && b <= 8'hEF) begin
            r = '{ok: 1'b1, pend: 2'd2, rng: RNG_ANY};
        end else if (b == 8'hF0) begin
            r = '{ok: 1'b1, pend: 2'd3, rng: RNG_90BF};
        end else if (b >= 8'hF1 && b <= 8'hF3) begin
            r = '{ok: 1'b1, pend: 2'd3, rng: RNG_ANY};
        end else if (b == 8'hF4) begin
            r = '{ok: 1'b1, pend: 2'd3, rng: RNG_808F};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: src/json_string_unescape_utf8_check_core.sv
// Top level: JSON string unescaper with strict UTF-8 checking of every emitted byte.
//
// Input channel (i_in_valid / o_in_ready) takes one raw byte of a JSON string
// literal per word, with i_first marking the opening quote and i_end_of_text the
// end of the text. Output channel (o_out_valid / i_out_ready) gives result words:
// a decoded UTF-8 byte (kind 0), literal closed and valid (kind 1) or malformed
// (kind 2); o_last marks the final result caused by one input word.
// Each accepted byte is decoded in the cycle it is accepted; its results sit in a
// four-entry result register and appear in the following cycle. Bytes causing one result
// or none stream at one per cycle while the receiver takes the results. A byte causing k
// results (a \uXXXX escape closing on a code point of k UTF-8 bytes) holds the input
// while the result register drains, one result per cycle while the receiver is ready.
// A new byte is taken in the cycle the last buffered result leaves, so while a
// result waits and the receiver stalls, the input is held as well.
// Reset (synchronous, active low) empties the result register and returns the
// parser to idle, awaiting an opening quote.
`default_nettype none
module json_string_unescape_utf8_check_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_first,
    input  wire logic       i_end_of_text,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic [1:0]      o_kind,
    output logic            o_last
);
    import jsu_pkg::*;

    typedef enum logic [2:0] {
        M_IDLE,
        M_BODY,
        M_ESC,
        M_HEXHI,
        M_WANTBS,
        M_WANTU,
        M_HEXLO
    } t_mode;

    // Parser state
    t_mode       r_mode,  n_mode;
    logic [15:0] r_acc,   n_acc;
    logic [1:0]  r_cnt,   n_cnt;
    logic [9:0]  r_hs,    n_hs;
    logic [1:0]  r_pend,  n_pend;
    logic [2:0]  r_rng,   n_rng;

    // Result register, drained from entry 0
    logic [7:0]  r_ob_byte [MAX_RES];
    logic [1:0]  r_ob_kind [MAX_RES];
    logic [2:0]  r_rem;

    // Decode outputs
    logic [7:0]  res_byte [MAX_RES];
    logic [1:0]  res_kind [MAX_RES];
    logic [2:0]  res_n;
    logic        res_fail;

    logic        eot;
    logic        hex_ok;
    logic [3:0]  hex_d;
    logic [15:0] acc_new;
    logic [20:0] cp;
    logic [7:0]  emit_b [MAX_RES];
    logic [2:0]  emit_k;
    logic        emit_cp;
    t_act        act;
    t_utf8       vs;
    logic [1:0]  v_pend;
    logic [2:0]  v_rng;
    logic        bad;
    logic        in_acc;
    logic        out_acc;

    assign in_acc     = i_in_valid && o_in_ready;
    assign out_acc    = o_out_valid && i_out_ready;
    assign o_out_valid = (r_rem != 3'd0);
    assign o_in_ready = (r_rem == 3'd0) || (i_out_ready && r_rem == 3'd1);
    assign o_out_byte = r_ob_byte[0];
    assign o_kind     = r_ob_kind[0];
    assign o_last     = (r_rem == 3'd1);

    assign eot = i_end_of_text || (i_in_byte == 8'h00);

    // Hex digit decode
    always_comb begin
        hex_ok = 1'b1;
        hex_d  = 4'd0;
        if (i_in_byte >= 8'h30 && i_in_byte <= 8'h39) begin
            hex_d = 4'(i_in_byte - 8'h30);
        end else if (i_in_byte >= 8'h61 && i_in_byte <= 8'h66) begin
            hex_d = 4'(i_in_byte - 8'h57);
        end else if (i_in_byte >= 8'h41 && i_in_byte <= 8'h46) begin
            hex_d = 4'(i_in_byte - 8'h37);
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign acc_new = {r_acc[11:0], hex_d};

    // Parse step: next state and the bytes to emit
    always_comb begin
        n_mode  = r_mode;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_hs    = r_hs;
        n_pend  = r_pend;
        n_rng   = r_rng;
        act     = ACT_NONE;
        emit_k  = 3'd0;
        emit_cp = 1'b0;
        cp      = {5'd0, acc_new};
        for (int i = 0; i < MAX_RES; i++) begin
            emit_b[i] = 8'h00;
        end

        if (i_first) begin
            n_acc  = '0;
            n_cnt  = '0;
            n_hs   = '0;
            n_pend = '0;
            n_rng  = RNG_ANY;
            if (eot || i_in_byte != CH_QUOTE) begin
                act = ACT_FAIL;
            end else begin
                n_mode = M_BODY;
            end
        end else if (r_mode == M_IDLE) begin
            n_mode = M_IDLE;
        end else if (eot) begin
            act = ACT_FAIL;
        end else begin
            case (r_mode)
                M_BODY: begin
                    if (i_in_byte == CH_QUOTE) begin
                        act = (r_pend != 2'd0) ? ACT_FAIL : ACT_CLOSE;
                    end else if (i_in_byte < CH_SPACE) begin
                        act = ACT_FAIL;
                    end else if (i_in_byte == CH_BSLASH) begin
                        n_mode = M_ESC;
                    end else begin
                        act       = ACT_EMIT;
                        emit_b[0] = i_in_byte;
                        emit_k    = 3'd1;
                    end
                end
                M_ESC: begin
                    act    = ACT_EMIT;
                    emit_k = 3'd1;
                    n_mode = M_BODY;
                    case (i_in_byte)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: emit_b[0] = i_in_byte;
                        CH_B: emit_b[0] = 8'h08;
                        CH_F: emit_b[0] = 8'h0C;
                        CH_N: emit_b[0] = 8'h0A;
                        CH_R: emit_b[0] = 8'h0D;
                        CH_T: emit_b[0] = 8'h09;
                        CH_U: begin
                            act    = ACT_NONE;
                            emit_k = 3'd0;
                            n_mode = M_HEXHI;
                            n_acc  = '0;
                            n_cnt  = '0;
                        end
                        default: begin
                            act    = ACT_FAIL;
                            emit_k = 3'd0;
                        end
                    endcase
                end
                M_HEXHI, M_HEXLO: begin
                    if (!hex_ok) begin
                        act = ACT_FAIL;
                    end else begin
                        n_acc = acc_new;
                        if (r_cnt == 2'd3) begin
                            n_cnt = 2'd0;
                            if (r_mode == M_HEXHI) begin
                                if (acc_new >= 16'hD800 && acc_new <= 16'hDBFF) begin
                                    // high surrogate: wait for its low half
                                    n_hs   = acc_new[9:0];
                                    n_mode = M_WANTBS;
                                end else if (acc_new >= 16'hDC00 && acc_new <= 16'hDFFF) begin
                                    act = ACT_FAIL;
                                end else if (acc_new == 16'h0000) begin
                                    act = ACT_FAIL;
                                end else begin
                                    emit_cp = 1'b1;
                                end
                            end else begin
                                if (acc_new < 16'hDC00 || acc_new > 16'hDFFF) begin
                                    act = ACT_FAIL;
                                end else begin
                                    cp      = 21'h10000 + {1'b0, r_hs, acc_new[9:0]};
                                    emit_cp = 1'b1;
                                end
                            end
                        end else begin
                            n_cnt = r_cnt + 2'd1;
                        end
                    end
                end
                M_WANTBS: begin
                    if (i_in_byte == CH_BSLASH) n_mode = M_WANTU;
                    else act = ACT_FAIL;
                end
                M_WANTU: begin
                    if (i_in_byte == CH_U) begin
                        n_mode = M_HEXLO;
                        n_acc  = '0;
                        n_cnt  = '0;
                    end else begin
                        act = ACT_FAIL;
                    end
                end
                default: n_mode = M_IDLE;
            endcase
        end

        // UTF-8 encode of an escaped code point
        if (emit_cp) begin
            act    = ACT_EMIT;
            n_mode = M_BODY;
            if (cp < 21'h80) begin
                emit_b[0] = cp[7:0];
                emit_k    = 3'd1;
            end else if (cp < 21'h800) begin
                emit_b[0] = {3'b110, cp[10:6]};
                emit_b[1] = {2'b10, cp[5:0]};
                emit_k    = 3'd2;
            end else if (cp < 21'h10000) begin
                emit_b[0] = {4'b1110, cp[15:12]};
                emit_b[1] = {2'b10, cp[11:6]};
                emit_b[2] = {2'b10, cp[5:0]};
                emit_k    = 3'd3;
            end else begin
                emit_b[0] = {5'b11110, cp[20:18]};
                emit_b[1] = {2'b10, cp[17:12]};
                emit_b[2] = {2'b10, cp[11:6]};
                emit_b[3] = {2'b10, cp[5:0]};
                emit_k    = 3'd4;
            end
        end
    end

    // Validator chain over the emitted bytes, then the result list
    always_comb begin
        v_pend   = r_pend;
        v_rng    = r_rng;
        bad      = 1'b0;
        res_n    = 3'd0;
        res_fail = 1'b0;
        vs       = '{ok: 1'b1, pend: r_pend, rng: r_rng};
        for (int i = 0; i < MAX_RES; i++) begin
            res_byte[i] = 8'h00;
            res_kind[i] = KIND_BYTE;
        end
        case (act)
            ACT_EMIT: begin
                for (int i = 0; i < MAX_RES; i++) begin
                    if (3'(i) < emit_k && !bad) begin
                        vs    = utf8_step(v_pend, v_rng, emit_b[i]);
                        res_n = 3'(i + 1);
                        if (vs.ok) begin
                            res_byte[i] = emit_b[i];
                            v_pend      = vs.pend;
                            v_rng       = vs.rng;
                        end else begin
                            res_kind[i] = KIND_BAD;
                            bad         = 1'b1;
                        end
                    end
                end
                res_fail = bad;
            end
            ACT_FAIL: begin
                res_kind[0] = KIND_BAD;
                res_n       = 3'd1;
                res_fail    = 1'b1;
            end
            ACT_CLOSE: begin
                res_kind[0] = KIND_OK;
                res_n       = 3'd1;
            end
            default: res_n = 3'd0;
        endcase
    end

    // State registers and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_acc  <= '0;
            r_cnt  <= '0;
            r_hs   <= '0;
            r_pend <= '0;
            r_rng  <= RNG_ANY;
            r_rem  <= '0;
        end else begin
            if (in_acc) begin
                if (res_fail || act == ACT_CLOSE) begin
                    // literal over: clear and wait for the next one
                    r_mode <= M_IDLE;
                    r_acc  <= '0;
                    r_cnt  <= '0;
                    r_hs   <= '0;
                    r_pend <= '0;
                    r_rng  <= RNG_ANY;
                end else begin
                    r_mode <= n_mode;
                    r_acc  <= n_acc;
                    r_cnt  <= n_cnt;
                    r_hs   <= n_hs;
                    r_pend <= (act == ACT_EMIT) ? v_pend : n_pend;
                    r_rng  <= (act == ACT_EMIT) ? v_rng : n_rng;
                end
            end
            if (in_acc) begin
                r_rem <= res_n;
            end else if (out_acc) begin
                r_rem <= r_rem - 3'd1;
            end
        end
    end

    // Result payload: load on accept, shift on take
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int i = 0; i < MAX_RES; i++) begin
                r_ob_byte[i] <= res_byte[i];
                r_ob_kind[i] <= res_kind[i];
            end
        end else if (out_acc) begin
            for (int i = 0; i < MAX_RES - 1; i++) begin
                r_ob_byte[i] <= r_ob_byte[i + 1];
                r_ob_kind[i] <= r_ob_kind[i + 1];
            end
        end
    end

    // Status words carry no byte and always end the list
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind != KIND_BYTE) |-> (o_last && o_out_byte == 8'h00))
        else $error("status word not last or carries a byte");

    // A malformed result leaves the parser idle and the validator clear
    a_fail_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && res_fail) |=> (r_mode == M_IDLE && r_pend == 2'd0))
        else $error("parser not idle after malformed");

    // Pending continuation bytes only inside a literal
    a_pend_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend != 2'd0) |-> (r_mode != M_IDLE))
        else $error("continuation pending while idle");

    // Input is taken only when the result register will be free
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && o_out_valid) |-> (out_acc && o_last))
        else $error("result register overrun");

endmodule
`default_nettype wire
